>>> src/lcdbg_pkg.sv
// Shared types and constants for the LCD mode timing and background line block.
// No dependencies.
package lcdbg_pkg;

    localparam int TilesPerLine = 20;
    localparam int VisibleLines = 144;
    localparam int ColW = 5;
    localparam int VramAw = 13;
    localparam int VramDepth = 8192;
    localparam int QDepth = 2;

    localparam logic [9:0] THblank = 10'd204;
    localparam logic [9:0] TOam = 10'd80;
    localparam logic [9:0] TDraw = 10'd172;
    localparam logic [9:0] TLine = 10'd456;
    localparam logic [7:0] LastLine = 8'd153;
    localparam logic [12:0] MapHiOff = 13'h1C00;
    localparam logic [12:0] MapLoOff = 13'h1800;
    localparam logic [12:0] DataHiOff = 13'h0000;
    localparam logic [12:0] DataLoOff = 13'h0800;
    localparam logic [9:0] AccReset = 10'd4;
    localparam logic [7:0] LcdcReset = 8'h91;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_DRAW   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CLEAR,
        BK_STATUS,
        BK_RD_IDX,
        BK_RD_LO,
        BK_RD_HI,
        BK_EMIT
    } bk_state_t;

    // Classified command passed from front to back.
    typedef struct packed {
        logic        is_write;
        logic [12:0] addr;
        logic [7:0]  data;
        logic [7:0]  duration;
    } cmd_t;

    typedef struct packed {
        logic        result_kind;
        logic [1:0]  mode;
        logic [7:0]  line;
        logic        vblank_irq;
        logic [4:0]  tile_column;
        logic [15:0] pixels;
        logic        last;
    } res_t;

    function automatic logic [15:0] pack_row(input logic [7:0] lo, input logic [7:0] hi);
        logic [15:0] acc;
        acc = '0;
        for (int k = 0; k < 8; k++) begin
            acc[2*k]   = lo[7-k];
            acc[2*k+1] = hi[7-k];
        end
        return acc;
    endfunction

endpackage

>>> src/lcdbg_front.sv
// Front part: accepts input items and queues classified commands.
// Depends on lcdbg_pkg.
module lcdbg_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  lcdbg_pkg::cmd_t   in_cmd,
    output logic              q_valid,
    input  logic              q_ready,
    output lcdbg_pkg::cmd_t   q_cmd
);
    lcdbg_pkg::cmd_t mem_reg [lcdbg_pkg::QDepth];
    logic            wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic            push, pop;

    assign in_ready = (cnt_reg != 2'(lcdbg_pkg::QDepth));
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = mem_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wp_next  = wp_reg + 1'(push);
        rp_next  = rp_reg + 1'(pop);
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= in_cmd;
        end
    end
endmodule

>>> src/lcdbg_back.sv
// Back part: mode timing, video store with clearing pass, line fetch.
// Depends on lcdbg_pkg.
module lcdbg_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [7:0]       lcd_control,
    input  logic             q_valid,
    output logic             q_ready,
    input  lcdbg_pkg::cmd_t  q_cmd,
    output logic             r_valid,
    input  logic             r_ready,
    output lcdbg_pkg::res_t  r_data
);
    logic [7:0] vram [lcdbg_pkg::VramDepth];

    lcdbg_pkg::bk_state_t state_reg, state_next;
    lcdbg_pkg::mode_t     mode_reg, mode_next;
    logic [9:0]  acc_reg, acc_next;
    logic [7:0]  line_reg, line_next;
    logic        irq_reg, irq_next, render_reg, render_next;
    logic [12:0] clr_reg, clr_next;
    logic [4:0]  col_reg, col_next;
    logic [7:0]  idx_reg, idx_next, lo_reg, lo_next;
    logic [7:0]  rd_reg;
    logic [12:0] rd_addr;
    logic        we;
    logic [12:0] wa;
    logic [7:0]  wd;
    logic [9:0]  t;
    logic [12:0] map_base, data_base, data_addr;
    logic [7:0]  line_inc;
    logic [7:0]  idx_cur;

    assign t         = acc_reg + 10'(q_cmd.duration);
    assign line_inc  = line_reg + 8'd1;
    assign map_base  = lcd_control[3] ? lcdbg_pkg::MapHiOff : lcdbg_pkg::MapLoOff;
    assign data_base = lcd_control[4] ? lcdbg_pkg::DataHiOff : lcdbg_pkg::DataLoOff;
    // The tile index arrives from the store during the low-plane read cycle
    assign idx_cur   = (state_reg == lcdbg_pkg::BK_RD_LO) ? rd_reg : idx_reg;
    assign data_addr = data_base + {1'b0, idx_cur, 4'b0} + {9'b0, line_reg[2:0], 1'b0};

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lcdbg_pkg::BK_CLEAR:
                if (clr_reg == 13'(lcdbg_pkg::VramDepth - 1)) state_next = lcdbg_pkg::BK_IDLE;
            lcdbg_pkg::BK_IDLE:
                if (q_valid && !q_cmd.is_write) state_next = lcdbg_pkg::BK_STATUS;
            lcdbg_pkg::BK_STATUS:
                if (r_ready) state_next = render_reg ? lcdbg_pkg::BK_RD_IDX
                                                     : lcdbg_pkg::BK_IDLE;
            lcdbg_pkg::BK_RD_IDX: state_next = lcdbg_pkg::BK_RD_LO;
            lcdbg_pkg::BK_RD_LO:  state_next = lcdbg_pkg::BK_RD_HI;
            lcdbg_pkg::BK_RD_HI:  state_next = lcdbg_pkg::BK_EMIT;
            lcdbg_pkg::BK_EMIT:
                if (r_ready) state_next =
                    (col_reg == 5'(lcdbg_pkg::TilesPerLine - 1)) ? lcdbg_pkg::BK_IDLE
                                                                 : lcdbg_pkg::BK_RD_IDX;
            default: state_next = lcdbg_pkg::BK_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        mode_next   = mode_reg;
        acc_next    = acc_reg;
        line_next   = line_reg;
        irq_next    = irq_reg;
        render_next = render_reg;
        clr_next    = clr_reg;
        col_next    = col_reg;
        idx_next    = idx_reg;
        lo_next     = lo_reg;
        q_ready     = 1'b0;
        we          = 1'b0;
        wa          = q_cmd.addr;
        wd          = q_cmd.data;
        rd_addr     = '0;
        r_valid     = 1'b0;
        r_data      = '0;
        r_data.mode = mode_reg;
        r_data.line = line_reg;
        case (state_reg)
            lcdbg_pkg::BK_CLEAR: begin
                we       = 1'b1;
                wa       = clr_reg;
                wd       = 8'd0;
                clr_next = clr_reg + 13'd1;
            end
            lcdbg_pkg::BK_IDLE: begin
                q_ready = 1'b1;
                if (q_valid && q_cmd.is_write) begin
                    we = 1'b1;
                end else if (q_valid) begin
                    acc_next    = t;
                    irq_next    = 1'b0;
                    render_next = 1'b0;
                    col_next    = '0;
                    case (mode_reg)
                        lcdbg_pkg::MODE_HBLANK:
                            if (t > lcdbg_pkg::THblank) begin
                                acc_next  = t - lcdbg_pkg::THblank;
                                line_next = line_inc;
                                if (line_inc >= 8'(lcdbg_pkg::VisibleLines)) begin
                                    mode_next = lcdbg_pkg::MODE_VBLANK;
                                    irq_next  = 1'b1;
                                end else begin
                                    mode_next = lcdbg_pkg::MODE_OAM;
                                end
                            end
                        lcdbg_pkg::MODE_VBLANK:
                            if (t > lcdbg_pkg::TLine) begin
                                acc_next = t - lcdbg_pkg::TLine;
                                if (line_reg >= lcdbg_pkg::LastLine) begin
                                    mode_next = lcdbg_pkg::MODE_OAM;
                                    line_next = 8'd0;
                                end else begin
                                    line_next = line_inc;
                                end
                            end
                        lcdbg_pkg::MODE_OAM:
                            if (t > lcdbg_pkg::TOam) begin
                                acc_next  = t - lcdbg_pkg::TOam;
                                mode_next = lcdbg_pkg::MODE_DRAW;
                            end
                        default:
                            if (t > lcdbg_pkg::TDraw) begin
                                acc_next    = t - lcdbg_pkg::TDraw;
                                mode_next   = lcdbg_pkg::MODE_HBLANK;
                                render_next = lcd_control[0];
                            end
                    endcase
                end
            end
            lcdbg_pkg::BK_STATUS: begin
                r_valid           = 1'b1;
                r_data.vblank_irq = irq_reg;
                r_data.last       = !render_reg;
            end
            lcdbg_pkg::BK_RD_IDX: begin
                rd_addr = map_base + {3'b0, line_reg[7:3], 5'b0} + 13'(col_reg);
            end
            lcdbg_pkg::BK_RD_LO: begin
                idx_next = rd_reg;
                rd_addr  = data_addr;
            end
            lcdbg_pkg::BK_RD_HI: begin
                lo_next = rd_reg;
                rd_addr = data_addr + 13'd1;
            end
            lcdbg_pkg::BK_EMIT: begin
                // keep reading the high plane so a stall holds the row
                rd_addr            = data_addr + 13'd1;
                r_valid            = 1'b1;
                r_data.result_kind = 1'b1;
                r_data.tile_column = col_reg;
                r_data.pixels      = lcdbg_pkg::pack_row(lo_reg, rd_reg);
                r_data.last        = (col_reg == 5'(lcdbg_pkg::TilesPerLine - 1));
                if (r_ready) col_next = col_reg + 5'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= lcdbg_pkg::BK_CLEAR;
            mode_reg   <= lcdbg_pkg::MODE_OAM;
            acc_reg    <= lcdbg_pkg::AccReset;
            line_reg   <= 8'd0;
            irq_reg    <= 1'b0;
            render_reg <= 1'b0;
            clr_reg    <= '0;
            col_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            acc_reg    <= acc_next;
            line_reg   <= line_next;
            irq_reg    <= irq_next;
            render_reg <= render_next;
            clr_reg    <= clr_next;
            col_reg    <= col_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        lo_reg  <= lo_next;
    end

    always_ff @(posedge aclk) begin
        if (we) vram[wa] <= wd;
        rd_reg <= vram[rd_addr];
    end
endmodule

>>> src/lcdbg_out_reg.sv
// Output register stage for result items.
// Depends on lcdbg_pkg.
module lcdbg_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             r_valid,
    output logic             r_ready,
    input  lcdbg_pkg::res_t  r_data,
    output logic             m_valid,
    input  logic             m_ready,
    output lcdbg_pkg::res_t  m_data
);
    logic            vld_reg, vld_next;
    lcdbg_pkg::res_t dat_reg;

    assign r_ready = !vld_reg || m_ready;
    assign m_valid = vld_reg;
    assign m_data  = dat_reg;
    assign vld_next = r_ready ? r_valid : vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= 1'b0;
        else          vld_reg <= vld_next;
    end

    always_ff @(posedge aclk) begin
        if (r_ready && r_valid) dat_reg <= r_data;
    end
endmodule

>>> src/lcd_mode_timing_and_bg_line_top.sv
// Channel  | dir | tdata                                   | tuser | tlast
// s_axis   | in  | duration[7:0] addr[20:8] data[28:21]    | kind  | -
// m_axis   | out | mode,line,irq,col,pixels (see port)     | kind  | last
// A write item is taken in the idle state; a status-only tick passes through the
// idle and status states. A rendering tick then fetches 20 tiles: each tile reads
// the index, low plane and high plane in sequence through the single video memory
// read port. After reset a clearing pass zeroes all 8192 entries of the video
// store; only the two queue entries fill meanwhile. A two-entry queue and an
// output register let either side stall independently.
// Depends on lcdbg_pkg, lcdbg_front, lcdbg_back, lcdbg_out_reg.
module lcd_mode_timing_and_bg_line_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // duration[7:0], vram_address[20:8], vram_data[28:21], zero[31:29]
    input  logic [31:0] s_axis_tdata,
    // kind
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // mode[1:0], line[9:2], vblank_irq[10], tile_column[15:11], pixels[31:16]
    output logic [31:0] m_axis_tdata,
    // result_kind
    output logic        m_axis_tuser,
    output logic        m_axis_tlast
);
    logic [7:0]      lcdc_reg;
    lcdbg_pkg::cmd_t in_cmd, q_cmd;
    lcdbg_pkg::res_t r_data, m_data;
    logic q_valid, q_ready, r_valid, r_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn)       lcdc_reg <= lcdbg_pkg::LcdcReset;
        else if (cfg_wr_en) lcdc_reg <= cfg_wr_data;
    end

    assign in_cmd.is_write = s_axis_tuser;
    assign in_cmd.duration = s_axis_tdata[7:0];
    assign in_cmd.addr     = s_axis_tdata[20:8];
    assign in_cmd.data     = s_axis_tdata[28:21];

    lcdbg_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd(in_cmd),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    lcdbg_back u_back (
        .aclk(aclk), .aresetn(aresetn), .lcd_control(lcdc_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .r_valid(r_valid), .r_ready(r_ready), .r_data(r_data)
    );

    lcdbg_out_reg u_out (
        .aclk(aclk), .aresetn(aresetn),
        .r_valid(r_valid), .r_ready(r_ready), .r_data(r_data),
        .m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .m_data(m_data)
    );

    assign m_axis_tdata = {m_data.pixels, m_data.tile_column, m_data.vblank_irq,
                           m_data.line, m_data.mode};
    assign m_axis_tuser = m_data.result_kind;
    assign m_axis_tlast = m_data.last;
endmodule

>>> src/lcdbg_checker.sv
// Port-level checks for the LCD timing block, bound to the top level.
// Depends on lcd_mode_timing_and_bg_line_top ports and lcdbg_pkg.
module lcdbg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_status_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[31:11] == 21'd0)
        else $error("status result carries tile data");

    a_row_noirq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[10]
            && m_axis_tdata[1:0] == 2'd0)
        else $error("tile row with irq or wrong mode");

    a_line_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[9:2] <= 8'd153)
        else $error("line out of range");

    a_row_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast
            == (m_axis_tdata[15:11] == 5'(lcdbg_pkg::TilesPerLine - 1)))
        else $error("tile row last flag misplaced");
endmodule

bind lcd_mode_timing_and_bg_line_top lcdbg_checker u_chk (
    .aclk(aclk), .aresetn(aresetn),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
);
